FILE: src/bitmap_block_allocator_macros.svh
// assertion macros for the bitmap block allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BBA_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap_block_allocator: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap_block_allocator: next-cycle check failed");

`endif

FILE: src/bba_pkg.sv
// shared types, constants and helper functions of the bitmap block allocator
package bba_pkg;

   localparam int unsigned MAX_BLOCKS_DEFAULT = 4096;

   localparam int unsigned WORD_BITS  = 64;
   localparam int unsigned WORD_SHIFT = 6;
   localparam int unsigned POS_W      = 14;
   localparam int unsigned WPOS_W     = POS_W - WORD_SHIFT;
   localparam int unsigned COUNT_W    = 13;
   localparam int unsigned START_W    = 12;
   localparam int unsigned KIND_W     = 2;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT   = 1'b0;
   localparam logic [COUNT_W-1:0]   BLOCK_COUNT_RESET = 13'd4096;

   localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OCCUPY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [START_W-1:0] start_block;
      logic [COUNT_W-1:0] run_length;
      logic [START_W-1:0] end_block;
   } req_word_type;

   typedef struct packed {
      logic               found;
      logic [START_W-1:0] run_start;
      logic [COUNT_W-1:0] free_total;
      logic [COUNT_W-1:0] used_total;
   } rsp_word_type;

   // bits j of a word starting at base for which base + j < limit
   function automatic logic [WORD_BITS-1:0] lt_mask(input logic [POS_W-1:0] base,
                                                    input logic [POS_W-1:0] limit);
      logic [POS_W-1:0]     diff;
      logic [WORD_BITS-1:0] m;
      diff = limit - base;
      if (limit <= base) begin
         m = '0;
      end else if (diff >= POS_W'(WORD_BITS)) begin
         m = '1;
      end else begin
         m = (WORD_BITS'(1) << diff[WORD_SHIFT-1:0]) - WORD_BITS'(1);
      end
      return m;
   endfunction

   function automatic logic [WORD_SHIFT:0] popcount(input logic [WORD_BITS-1:0] v);
      logic [WORD_SHIFT:0] s [WORD_BITS];
      for (int i = 0; i < WORD_BITS; i++) begin
         s[i] = (WORD_SHIFT + 1)'(v[i]);
      end
      for (int w = WORD_BITS / 2; w >= 1; w = w / 2) begin
         for (int i = 0; i < w; i++) begin
            s[i] = s[2 * i] + s[2 * i + 1];
         end
      end
      return s[0];
   endfunction

endpackage

FILE: src/bitmap_block_allocator.sv
// bitmap block allocator: first-fit run search, range occupy/free and range count
// occupancy held in a 64-bit-wide memory, one word read per cycle, read-modify-write for updates
// sequence: accept, scan each 64-block word touched, then post the result word
// a new request is taken only in idle, after the previous one has posted its result word
// reset: block_count returns to 4096; a clearing pass zeroes every word of the map
// no request is taken during the clearing pass; register writes are taken at all times
`include "bitmap_block_allocator_macros.svh"

module bitmap_block_allocator #(
   parameter int unsigned MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  bba_pkg::req_word_type              req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output bba_pkg::rsp_word_type              rsp_word,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bba_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bba_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bba_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import bba_pkg::*;

   localparam int unsigned WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [WAW-1:0] CLR_LAST = WAW'(WORDS - 1);
   localparam logic [31:0]    MAX_LIMIT = 32'(MAX_BLOCKS);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_POST
   } state_type;

   state_type             state_ff, state_in;
   logic [WAW-1:0]        clr_ff, clr_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [COUNT_W-1:0]    len_ff, len_in;
   logic [POS_W-1:0]      lo_ff, lo_in;
   logic [POS_W-1:0]      hi_ff, hi_in;
   logic [WPOS_W-1:0]     cur_ff, cur_in;
   logic [WPOS_W-1:0]     last_ff, last_in;
   logic [COUNT_W-1:0]    carry_ff, carry_in;
   logic [COUNT_W-1:0]    free_ff, free_in;
   logic [COUNT_W-1:0]    used_ff, used_in;
   rsp_word_type          res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;
   logic [COUNT_W-1:0]    block_count_ff, block_count_in;

   logic [WORD_BITS-1:0]  map_mem [WORDS];
   logic [WORD_BITS-1:0]  rdata_ff;
   logic                  mem_we;
   logic [WAW-1:0]        mem_waddr;
   logic [WAW-1:0]        mem_raddr;
   logic [WORD_BITS-1:0]  mem_wdata;

   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;

   logic [COUNT_W-1:0]    n_eff;
   logic [COUNT_W-1:0]    n_less1;
   logic [COUNT_W-1:0]    cnt_last;
   logic [COUNT_W-1:0]    end_ext;
   logic [POS_W-1:0]      occ_stop;
   logic [POS_W-1:0]      acc_lo;
   logic [POS_W-1:0]      acc_hi;
   logic [POS_W-1:0]      acc_hi_less1;
   logic                  acc_empty;
   logic [WPOS_W-1:0]     acc_first;
   logic [WPOS_W-1:0]     acc_last;

   logic [POS_W-1:0]      base;
   logic [WORD_BITS-1:0]  range_mask;
   logic [WORD_BITS-1:0]  occ_view;
   logic [WORD_BITS-1:0]  pf_has [WORD_SHIFT+1];
   logic [WORD_SHIFT-1:0] pf_idx [WORD_SHIFT+1][WORD_BITS];
   logic [POS_W-1:0]      run_len [WORD_BITS];
   logic [WORD_BITS-1:0]  hit;
   logic [WORD_BITS-1:0]  hit_one;
   logic                  hit_any;
   logic [WORD_SHIFT-1:0] hit_pos;
   logic [POS_W-1:0]      found_pos;
   logic [POS_W-1:0]      carry_wide;
   logic [WORD_SHIFT:0]   pc_used;
   logic [WORD_SHIFT:0]   pc_free;
   logic [COUNT_W-1:0]    free_sum;
   logic [COUNT_W-1:0]    used_sum;
   logic                  at_last;

   // register port
   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (csr_index == CSR_BLOCK_COUNT) ? CSR_DATA_W'(block_count_ff) : '0;

   always_comb begin
      block_count_in = block_count_ff;
      if (csr_write && csr_index == CSR_BLOCK_COUNT) begin
         block_count_in = pwdata[COUNT_W-1:0];
      end
   end

   // effective block count and request decode
   assign n_eff   = (32'(block_count_ff) > MAX_LIMIT) ? COUNT_W'(MAX_LIMIT) : block_count_ff;
   assign n_less1 = n_eff - COUNT_W'(1);
   assign end_ext = COUNT_W'(req_word.end_block);
   assign cnt_last = (end_ext < n_less1) ? end_ext : n_less1;
   assign occ_stop = POS_W'(req_word.start_block) + POS_W'(req_word.run_length);

   always_comb begin
      case (req_word.kind)
         KIND_FIND: begin
            acc_lo    = '0;
            acc_hi    = POS_W'(n_eff);
            acc_empty = (n_eff == '0) || (req_word.run_length == '0);
         end
         KIND_OCCUPY, KIND_FREE: begin
            acc_lo    = POS_W'(req_word.start_block);
            acc_hi    = (occ_stop > POS_W'(n_eff)) ? POS_W'(n_eff) : occ_stop;
            acc_empty = (req_word.run_length == '0) ||
                        (POS_W'(req_word.start_block) >= POS_W'(n_eff));
         end
         KIND_COUNT: begin
            acc_lo    = POS_W'(req_word.start_block);
            acc_hi    = POS_W'(cnt_last) + POS_W'(1);
            acc_empty = (n_eff == '0) || (COUNT_W'(req_word.start_block) > cnt_last);
         end
         default: begin
            acc_lo    = '0;
            acc_hi    = '0;
            acc_empty = 1'b1;
         end
      endcase
   end

   assign acc_hi_less1 = acc_hi - POS_W'(1);
   assign acc_first    = acc_lo[POS_W-1:WORD_SHIFT];
   assign acc_last     = acc_hi_less1[POS_W-1:WORD_SHIFT];

   // word datapath
   assign base       = {cur_ff, {WORD_SHIFT{1'b0}}};
   assign range_mask = lt_mask(base, hi_ff) & ~lt_mask(base, lo_ff);
   assign occ_view   = rdata_ff | ~range_mask;

   // prefix scan: nearest occupied bit at or below each position
   always_comb begin
      pf_has[0] = occ_view;
      for (int j = 0; j < WORD_BITS; j++) begin
         pf_idx[0][j] = WORD_SHIFT'(j);
      end
      for (int k = 0; k < WORD_SHIFT; k++) begin
         pf_has[k+1] = pf_has[k];
         for (int j = 0; j < WORD_BITS; j++) begin
            pf_idx[k+1][j] = pf_idx[k][j];
            if (j >= (1 << k) && !pf_has[k][j]) begin
               pf_has[k+1][j] = pf_has[k][j - (1 << k)];
               pf_idx[k+1][j] = pf_idx[k][j - (1 << k)];
            end
         end
      end
   end

   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         if (pf_has[WORD_SHIFT][j]) begin
            run_len[j] = POS_W'(WORD_SHIFT'(j) - pf_idx[WORD_SHIFT][j]);
         end else begin
            run_len[j] = POS_W'(carry_ff) + POS_W'(j) + POS_W'(1);
         end
         hit[j] = run_len[j] >= POS_W'(len_ff);
      end
   end

   assign hit_any = |hit;
   assign hit_one = hit & (~hit + WORD_BITS'(1));

   always_comb begin
      hit_pos = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (hit_one[j]) begin
            hit_pos = hit_pos | WORD_SHIFT'(j);
         end
      end
   end

   assign found_pos  = base + POS_W'(hit_pos) + POS_W'(1) - POS_W'(len_ff);
   assign carry_wide = pf_has[WORD_SHIFT][WORD_BITS-1]
                     ? POS_W'(WORD_SHIFT'(WORD_BITS - 1) - pf_idx[WORD_SHIFT][WORD_BITS-1])
                     : POS_W'(carry_ff) + POS_W'(WORD_BITS);

   assign pc_used  = popcount(rdata_ff & range_mask);
   assign pc_free  = popcount(~rdata_ff & range_mask);
   assign free_sum = free_ff + COUNT_W'(pc_free);
   assign used_sum = used_ff + COUNT_W'(pc_used);
   assign at_last  = (cur_ff == last_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      kind_in      = kind_ff;
      len_in       = len_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      carry_in     = carry_ff;
      free_in      = free_ff;
      used_in      = used_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_raddr    = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + WAW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            mem_raddr = WAW'(acc_first);
            if (req_valid) begin
               kind_in  = req_word.kind;
               len_in   = req_word.run_length;
               lo_in    = acc_lo;
               hi_in    = acc_hi;
               cur_in   = acc_first;
               last_in  = acc_last;
               carry_in = '0;
               free_in  = '0;
               used_in  = '0;
               res_in   = '0;
               state_in = acc_empty ? ST_POST : ST_SCAN;
            end
         end
         ST_SCAN: begin
            mem_raddr = WAW'(cur_ff + WPOS_W'(1));
            case (kind_ff)
               KIND_FIND: begin
                  if (hit_any) begin
                     res_in.found     = 1'b1;
                     res_in.run_start = found_pos[START_W-1:0];
                     state_in         = ST_POST;
                  end else if (at_last) begin
                     state_in = ST_POST;
                  end else begin
                     cur_in   = cur_ff + WPOS_W'(1);
                     carry_in = carry_wide[COUNT_W-1:0];
                  end
               end
               KIND_OCCUPY, KIND_FREE: begin
                  mem_we    = 1'b1;
                  mem_waddr = WAW'(cur_ff);
                  mem_wdata = (kind_ff == KIND_OCCUPY) ? (rdata_ff | range_mask)
                                                       : (rdata_ff & ~range_mask);
                  if (at_last) begin
                     state_in = ST_POST;
                  end else begin
                     cur_in = cur_ff + WPOS_W'(1);
                  end
               end
               KIND_COUNT: begin
                  free_in = free_sum;
                  used_in = used_sum;
                  if (at_last) begin
                     res_in.free_total = free_sum;
                     res_in.used_total = used_sum;
                     state_in          = ST_POST;
                  end else begin
                     cur_in = cur_ff + WPOS_W'(1);
                  end
               end
               default: begin
                  state_in = ST_POST;
               end
            endcase
         end
         ST_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         block_count_ff <= BLOCK_COUNT_RESET;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
         block_count_ff <= block_count_in;
         kind_ff        <= kind_in;
         len_ff         <= len_in;
         lo_ff          <= lo_in;
         hi_ff          <= hi_in;
         cur_ff         <= cur_in;
         last_ff        <= last_in;
         carry_ff       <= carry_in;
         free_ff        <= free_in;
         used_ff        <= used_in;
         res_ff         <= res_in;
         rsp_word_ff    <= rsp_word_in;
      end
   end

   // occupancy memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= map_mem[mem_raddr];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `BBA_ASSERT_HOLDS(a_mem_write_source, clock, reset, mem_we, state_ff == ST_CLEAR || (state_ff == ST_SCAN && (kind_ff == KIND_OCCUPY || kind_ff == KIND_FREE)))
   `BBA_ASSERT_HOLDS(a_scan_in_bounds, clock, reset, state_ff == ST_SCAN, cur_ff <= last_ff)
   `BBA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff != ST_IDLE)
   `BBA_ASSERT_HOLDS(a_found_has_no_totals, clock, reset, rsp_valid && rsp_word.found, rsp_word.free_total == '0 && rsp_word.used_total == '0)

endmodule

FILE: sim/tb_bitmap_block_allocator.sv
// testbench for the bitmap block allocator: shadow bitmap, random requests and result checks
`timescale 1ns / 1ps

class allocator_shadow;
   bit                    occupied [bba_pkg::MAX_BLOCKS_DEFAULT];
   logic [12:0]           block_count;
   bba_pkg::rsp_word_type pending_answers [$];
   bba_pkg::rsp_word_type last_answer;
   int unsigned           faults;

   function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      block_count = bba_pkg::BLOCK_COUNT_RESET;
      last_answer = '0;
      faults      = 0;
   endfunction

   function int unsigned managed_blocks();
      if (block_count > bba_pkg::MAX_BLOCKS_DEFAULT) begin
         return bba_pkg::MAX_BLOCKS_DEFAULT;
      end
      return block_count;
   endfunction

   function void note_request(bba_pkg::req_word_type r);
      bba_pkg::rsp_word_type a;
      int unsigned           n;
      int unsigned           run;
      int unsigned           stop;
      int unsigned           last_blk;
      a   = '0;
      n   = managed_blocks();
      run = 0;
      case (r.kind)
         bba_pkg::KIND_FIND: begin
            if (r.run_length != 0) begin
               for (int unsigned i = 0; i < n; i++) begin
                  if (occupied[i]) begin
                     run = 0;
                  end else begin
                     run++;
                     if (run == r.run_length) begin
                        a.found     = 1'b1;
                        a.run_start = 12'(i + 1 - run);
                        break;
                     end
                  end
               end
            end
         end
         bba_pkg::KIND_OCCUPY, bba_pkg::KIND_FREE: begin
            stop = r.start_block + r.run_length;
            if (stop > n) stop = n;
            for (int unsigned i = r.start_block; i < stop; i++) begin
               occupied[i] = (r.kind == bba_pkg::KIND_OCCUPY);
            end
         end
         bba_pkg::KIND_COUNT: begin
            if (n != 0) begin
               last_blk = (r.end_block < n - 1) ? r.end_block : n - 1;
               for (int unsigned i = r.start_block; i <= last_blk; i++) begin
                  if (occupied[i]) a.used_total = a.used_total + 1'b1;
                  else a.free_total = a.free_total + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      last_answer = a;
      pending_answers.push_back(a);
   endfunction

   function void compare_field(string name, logic [12:0] want, logic [12:0] got);
      if (got !== want) begin
         faults++;
         $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   function void check_answer(bba_pkg::rsp_word_type got);
      bba_pkg::rsp_word_type want;
      if (pending_answers.size() == 0) begin
         faults++;
         $display("%0t result word expected none actual %h", $time, got);
      end else begin
         want = pending_answers.pop_front();
         compare_field("found", want.found, got.found);
         compare_field("run_start", want.run_start, got.run_start);
         compare_field("free_total", want.free_total, got.free_total);
         compare_field("used_total", want.used_total, got.used_total);
      end
   endfunction
endclass

module tb_bitmap_block_allocator;
   import bba_pkg::*;

   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned SETTLE_CYCLES = 80;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_word_type          req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_word_type          rsp_word;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   allocator_shadow shadow;
   int unsigned     send_idle_pct;
   int unsigned     recv_idle_pct;
   bit              hold_request;
   req_word_type    held_runs [$];

   bitmap_block_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #30_000_000;
      $display("bitmap_block_allocator: mismatch");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            for (int unsigned c = 0; c < HOLD_CYCLES; c++) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) shadow.check_answer(rsp_word);
   end

   function automatic req_word_type make_word(logic [KIND_W-1:0] kind, logic [11:0] first,
                                              logic [12:0] len, logic [11:0] last_blk);
      req_word_type w;
      w.kind        = kind;
      w.start_block = first;
      w.run_length  = len;
      w.end_block   = last_blk;
      return w;
   endfunction

   function automatic req_word_type random_request(int unsigned blocks);
      req_word_type w;
      int unsigned  pick;
      int unsigned  top;
      int unsigned  k;
      int unsigned  tail;
      top = (blocks == 0) ? 0 : blocks - 1;
      w.start_block = ($urandom_range(99, 0) < 85) ? 12'($urandom_range(top, 0))
                                                   : 12'($urandom);
      pick = $urandom_range(99, 0);
      if (pick < 70) w.run_length = 13'($urandom_range(16, 1));
      else if (pick < 85) w.run_length = 13'($urandom_range(256, 17));
      else if (pick < 90) w.run_length = '0;
      else if (pick < 95) w.run_length = 13'($urandom_range(4096, 257));
      else w.run_length = 13'($urandom_range(8191, 4097));
      tail = w.start_block + $urandom_range(300, 0);
      if (tail > 4095) tail = 4095;
      w.end_block = ($urandom_range(99, 0) < 70) ? 12'(tail) : 12'($urandom);
      pick = $urandom_range(99, 0);
      if (pick < 30) begin
         w.kind = KIND_FIND;
      end else if (pick < 50) begin
         w.kind = KIND_OCCUPY;
      end else if (pick < 80) begin
         w.kind = KIND_FREE;
         // mostly give back a run handed out earlier
         if (held_runs.size() != 0 && $urandom_range(99, 0) < 70) begin
            k = $urandom_range(held_runs.size() - 1, 0);
            w.start_block = held_runs[k].start_block;
            w.run_length  = held_runs[k].run_length;
            held_runs.delete(k);
         end
      end else begin
         w.kind = KIND_COUNT;
      end
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shadow.note_request(w);
      @(negedge clock);
   endtask

   task automatic wait_for_answers();
      while (shadow.pending_answers.size() != 0) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic write_block_count(input logic [12:0] value);
      wait_for_answers();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_BLOCK_COUNT, 2'b00};
      pwdata  <= {19'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      shadow.block_count = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic run_phase(input logic [12:0] blocks, input int unsigned items,
                            input bit with_hold);
      req_word_type w;
      req_word_type grab;
      int unsigned  done;
      bit           held;
      bit           paused;
      done   = 0;
      held   = 1'b0;
      paused = 1'b0;
      write_block_count(blocks);
      while (done < items) begin
         if (with_hold && !held && done >= items / 4) begin
            hold_request = 1'b1;
            held         = 1'b1;
         end
         if (with_hold && !paused && done >= items / 2) begin
            wait_for_answers();
            paused = 1'b1;
         end
         w = random_request(shadow.managed_blocks());
         send_word(w);
         done++;
         // claim the run just found
         if (w.kind == KIND_FIND && shadow.last_answer.found && $urandom_range(99, 0) < 60) begin
            grab = make_word(KIND_OCCUPY, shadow.last_answer.run_start, w.run_length,
                             12'($urandom));
            send_word(grab);
            held_runs.push_back(grab);
            done++;
         end
      end
   endtask

   initial begin
      shadow        = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_word      = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      hold_request  = 1'b0;
      send_idle_pct = 14;
      recv_idle_pct = 85;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(make_word(KIND_FIND, 12'd0, 13'd1, 12'd0));
      send_word(make_word(KIND_FIND, 12'd4095, 13'd4096, 12'd4095));
      send_word(make_word(KIND_FIND, 12'd0, 13'd0, 12'd0));
      send_word(make_word(KIND_FIND, 12'd0, 13'd4097, 12'd0));
      send_word(make_word(KIND_OCCUPY, 12'd4000, 13'd8191, 12'd0));
      send_word(make_word(KIND_COUNT, 12'd3990, 13'd0, 12'd4095));
      send_word(make_word(KIND_OCCUPY, 12'd10, 13'd0, 12'd0));
      send_word(make_word(KIND_OCCUPY, 12'd10, 13'd5, 12'd0));
      send_word(make_word(KIND_FIND, 12'd0, 13'd10, 12'd0));
      send_word(make_word(KIND_FIND, 12'd0, 13'd11, 12'd0));
      send_word(make_word(KIND_COUNT, 12'd4095, 13'd0, 12'd0));
      send_word(make_word(KIND_FREE, 12'd0, 13'd8191, 12'd0));
      send_word(make_word(KIND_OCCUPY, 12'd0, 13'd4096, 12'd0));
      send_word(make_word(KIND_FIND, 12'd0, 13'd1, 12'd0));
      send_word(make_word(KIND_COUNT, 12'd0, 13'd0, 12'd4095));
      send_word(make_word(KIND_FREE, 12'd4095, 13'd1, 12'd0));
      send_word(make_word(KIND_FIND, 12'd0, 13'd1, 12'd0));
      send_word(make_word(KIND_FREE, 12'd0, 13'd4096, 12'd0));
      write_block_count(13'd0);
      send_word(make_word(KIND_FIND, 12'd0, 13'd1, 12'd0));
      send_word(make_word(KIND_OCCUPY, 12'd0, 13'd9, 12'd0));
      send_word(make_word(KIND_COUNT, 12'd0, 13'd0, 12'd4095));
      write_block_count(13'd8191);
      send_word(make_word(KIND_FIND, 12'd0, 13'd4096, 12'd0));
      send_word(make_word(KIND_COUNT, 12'd0, 13'd0, 12'd4095));

      run_phase(13'd8191, 150, 1'b0);
      run_phase(13'd1, 30, 1'b0);
      run_phase(13'd64, 150, 1'b0);

      send_idle_pct = 85;
      recv_idle_pct = 14;
      run_phase(13'd4096, 250, 1'b1);
      run_phase(13'd200, 200, 1'b0);
      run_phase(13'd0, 20, 1'b0);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(13'd5000, 150, 1'b0);
      run_phase(13'd1000, 200, 1'b0);
      run_phase(13'd4096, 300, 1'b0);

      wait_for_answers();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (shadow.faults == 0) begin
         $display("bitmap_block_allocator: match");
      end else begin
         $display("bitmap_block_allocator: mismatch");
      end
      $finish;
   end
endmodule
